### hdl/weighted_union_find_macros.svh
// Assertion macros for the weighted union-find engine.
`ifndef WEIGHTED_UNION_FIND_MACROS_SVH
`define WEIGHTED_UNION_FIND_MACROS_SVH
`ifndef SYNTHESIS
`define WUF_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define WUF_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define WUF_ASSERT_IMP(label, clk, rst, pre, post)
`define WUF_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### hdl/wuf_pkg.sv
// Shared types and constants of the weighted union-find engine.
`default_nettype none
package wuf_pkg;
  localparam int unsigned ELEMENTS = 256;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned SIZE_W = 9;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int unsigned STEP_W = $clog2(ELEMENTS + 1);
  localparam int unsigned Q_DEPTH = 2;
  localparam logic MODE_QUERY = 1'b0;
  localparam logic MODE_UNION = 1'b1;

  typedef struct packed {
    logic             mode;
    logic             bad;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
  } wuf_cmd_t;
endpackage
`default_nettype wire

### hdl/wuf_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module wuf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### hdl/wuf_front.sv
// Front end: range check of requests and a short command queue.
`default_nettype none
module wuf_front import wuf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             mode,
  input  wire logic [IDX_W-1:0] first_index,
  input  wire logic [IDX_W-1:0] second_index,
  input  wire logic [CNT_W-1:0] element_count,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output wuf_cmd_t              head
);
  wuf_cmd_t q [Q_DEPTH];
  logic [0:0] wp, rp;
  logic [1:0] cnt;
  logic push;
  logic bad;
  localparam logic [CNT_W:0] ElemLim = (CNT_W+1)'(ELEMENTS);

  assign full = (cnt == 2'(Q_DEPTH));
  assign empty = (cnt == 2'd0);
  assign push = start && !full;
  assign head = q[rp];
  always_comb begin
    bad = ({1'b0, element_count} <= {2'b0, first_index}) ||
          ({1'b0, element_count} <= {2'b0, second_index}) ||
          ({2'b0, first_index} >= ElemLim) || ({2'b0, second_index} >= ElemLim);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= '{mode: mode, bad: bad, first: first_index, second: second_index};
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

### hdl/wuf_back.sv
// Back end: root walks and union over the parent and size tables.
`default_nettype none
module wuf_back import wuf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        empty,
  input  wuf_cmd_t         head,
  output logic             pop,
  output logic             done,
  output logic             same_set,
  output logic             out_of_range,
  output logic             idle
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_WAIT, S_CHK, S_SZ_WAIT, S_SZ, S_LINK
  } state_t;
  state_t state;

  logic [AW-1:0] clr;
  logic [IDX_W-1:0] node, root_a;
  logic phase;
  logic [STEP_W-1:0] steps;
  wuf_cmd_t cmd;
  logic [SIZE_W-1:0] size_a;
  logic sz_phase;

  logic p_we, s_we;
  logic [AW-1:0] p_addr, s_addr;
  logic [IDX_W-1:0] p_wd, p_rd;
  logic [SIZE_W-1:0] s_wd, s_rd;
  logic [SIZE_W:0] sum;
  logic [SIZE_W-1:0] sum_sat;
  logic a_small;

  wuf_ram #(.WIDTH(IDX_W), .DEPTH(ELEMENTS)) u_par (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wd), .rdata(p_rd));
  wuf_ram #(.WIDTH(SIZE_W), .DEPTH(ELEMENTS)) u_size (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));

  assign sum = {1'b0, size_a} + {1'b0, s_rd};
  assign sum_sat = sum[SIZE_W] ? '1 : sum[SIZE_W-1:0];
  assign a_small = size_a < s_rd;
  assign idle = (state == S_IDLE) && empty;
  assign pop = (state == S_IDLE) && !empty;

  always_comb begin
    p_we = 1'b0;
    s_we = 1'b0;
    p_addr = AW'(node);
    s_addr = AW'(root_a);
    p_wd = IDX_W'(clr);
    s_wd = SIZE_W'(1);
    unique case (state)
      S_CLEAR: begin
        p_we = 1'b1;
        s_we = 1'b1;
        p_addr = clr;
        s_addr = clr;
      end
      S_SZ_WAIT: s_addr = sz_phase ? AW'(node) : AW'(root_a);
      S_SZ: s_addr = AW'(node);
      S_LINK: begin
        p_we = 1'b1;
        s_we = 1'b1;
        p_addr = a_small ? AW'(root_a) : AW'(node);
        p_wd = a_small ? node : root_a;
        s_addr = a_small ? AW'(node) : AW'(root_a);
        s_wd = sum_sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      done <= 1'b0;
      same_set <= 1'b0;
      out_of_range <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == AW'(ELEMENTS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (!empty) begin
          cmd <= head;
          if (head.bad) begin
            done <= 1'b1;
            same_set <= 1'b0;
            out_of_range <= 1'b1;
          end else begin
            node <= head.first;
            phase <= 1'b0;
            steps <= '0;
            state <= S_RD;
          end
        end
        S_RD: state <= S_WAIT;
        S_WAIT: state <= S_CHK;
        S_CHK: begin
          if (p_rd == node || steps == STEP_W'(ELEMENTS)) begin
            if (!phase) begin
              root_a <= node;
              node <= cmd.second;
              phase <= 1'b1;
              steps <= '0;
              state <= S_RD;
            end else begin
              same_set <= (node == root_a);
              out_of_range <= 1'b0;
              done <= 1'b1;
              if (cmd.mode == MODE_UNION && node != root_a) begin
                sz_phase <= 1'b0;
                state <= S_SZ_WAIT;
              end else begin
                state <= S_IDLE;
              end
            end
          end else begin
            node <= p_rd;
            steps <= steps + 1'b1;
            state <= S_RD;
          end
        end
        S_SZ_WAIT: begin
          if (!sz_phase) begin
            sz_phase <= 1'b1;
          end else begin
            size_a <= s_rd;
            state <= S_SZ;
          end
        end
        S_SZ: state <= S_LINK;
        S_LINK: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hdl/weighted_union_find.sv
// Top level of the weighted union-find engine.
// Steps: S_IDLE takes a request from the queue and flags an out-of-range one;
// each element on either root walk, the root included, passes through S_RD,
// S_WAIT and S_CHK; a joining union then runs S_SZ_WAIT, S_SZ and S_LINK.
// Throughput: one request at a time in the back end; two requests may queue.
// Reset: synchronous; afterwards a clearing pass writes every entry of both
// tables while requests queue, busy rising once two wait. The result is a strobe.
`default_nettype none
module weighted_union_find import wuf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             mode,
  input  wire logic [IDX_W-1:0] first_index,
  input  wire logic [IDX_W-1:0] second_index,
  output logic                  done,
  output logic                  same_set,
  output logic                  out_of_range,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);
`include "weighted_union_find_macros.svh"

  // The element count is the single configuration register.
  logic [CNT_W-1:0] element_count;
  logic full, empty, pop, idle;
  wuf_cmd_t head;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= CNT_W'(256);
    end else if (cfg_valid) begin
      element_count <= cfg_data;
    end
  end

  // The front end range-checks each request as it arrives and queues it.
  wuf_front u_front (
    .clk(clk), .rst(rst), .start(start), .mode(mode),
    .first_index(first_index), .second_index(second_index),
    .element_count(element_count), .full(full), .pop(pop),
    .empty(empty), .head(head));

  // The back end walks the trees and carries out unions.
  wuf_back u_back (
    .clk(clk), .rst(rst), .empty(empty), .head(head), .pop(pop),
    .done(done), .same_set(same_set), .out_of_range(out_of_range),
    .idle(idle));

  assign busy = full;

  `WUF_ASSERT_IMP(a_flags_excl, clk, rst, done, !(same_set && out_of_range))
  `WUF_ASSERT_NEXT(a_pop_done, clk, rst, pop && head.bad, done && out_of_range)
  `WUF_ASSERT_IMP(a_idle_empty, clk, rst, idle, !full)
endmodule
`default_nettype wire

### test/weighted_union_find_tb.sv
// Self-checking testbench for the weighted union-find engine.
`default_nettype none
module weighted_union_find_tb;
  import wuf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: holds its own copy of the disjoint-set tables and the element
  // count, predicts the verdict of every accepted request and checks each
  // strobed result against the oldest prediction.
  class union_find_scoreboard;
    logic [IDX_W-1:0]  parent_of [ELEMENTS];
    logic [SIZE_W-1:0] size_of [ELEMENTS];
    logic [CNT_W-1:0]  element_limit;
    logic [1:0]        pending_verdicts[$];
    int                mismatches;

    function void clear();
      for (int k = 0; k < ELEMENTS; k++) begin
        parent_of[k] = IDX_W'(k);
        size_of[k] = SIZE_W'(1);
      end
      element_limit = CNT_W'(256);
      pending_verdicts.delete();
      mismatches = 0;
    endfunction

    function int root_of(int node);
      for (int s = 0; s < ELEMENTS; s++) begin
        if (int'(parent_of[node]) == node) break;
        node = parent_of[node];
      end
      return node;
    endfunction

    // Notes an accepted request and updates the tables as the block should.
    function void note_request(logic op, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
      int ra, rb, total;
      if (a >= element_limit || b >= element_limit) begin
        pending_verdicts.push_back(2'b01);
        return;
      end
      ra = root_of(a);
      rb = root_of(b);
      pending_verdicts.push_back({ra == rb, 1'b0});
      if (op == MODE_UNION && ra != rb) begin
        total = size_of[ra] + size_of[rb];
        if (total > 511) total = 511;
        if (size_of[ra] < size_of[rb]) begin
          parent_of[ra] = IDX_W'(rb);
          size_of[rb] = SIZE_W'(total);
        end else begin
          parent_of[rb] = IDX_W'(ra);
          size_of[ra] = SIZE_W'(total);
        end
      end
    endfunction

    task check_result(logic same, logic flag);
      logic [1:0] want;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      want = pending_verdicts.pop_front();
      if (same !== want[1]) report_mismatch("same_set differs");
      if (flag !== want[0]) report_mismatch("out_of_range differs");
    endtask

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic mode = 0;
  logic [IDX_W-1:0] first_index = 0, second_index = 0;
  logic cfg_valid = 0;
  logic [CNT_W-1:0] cfg_data = 0;
  logic busy, done, same_set, out_of_range, cfg_ready;
  logic quiet_phase = 0;
  int unsigned cycle_count = 0;
  union_find_scoreboard tables;

  always #5 clk = ~clk;

  weighted_union_find DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .first_index(first_index), .second_index(second_index), .done(done),
    .same_set(same_set), .out_of_range(out_of_range), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Results are taken at the rising edge that closes their strobe cycle.
  always @(posedge clk) begin
    if (!rst && done) tables.check_result(same_set, out_of_range);
  end

  // Watchdog: ends the run as broken past this limit, far above what even two
  // full-length root walks for one request can need.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 6_000_000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Optional random gap before a request, never in the quiet phase.
  // Start drops only for a gap, so back-to-back requests keep it high.
  task automatic idle_gap();
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  // Presents one request and holds it until the block takes it.
  task automatic issue_request(logic op, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    idle_gap();
    start <= 1;
    mode <= op;
    first_index <= a;
    second_index <= b;
    do @(posedge clk); while (busy);
    tables.note_request(op, a, b);
    @(negedge clk);
  endtask

  // Drains outstanding results, lets the back end settle, then writes the count.
  task automatic set_element_count(logic [CNT_W-1:0] value);
    start <= 0;
    while (tables.pending_verdicts.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    tables.element_limit = value;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Random request: most indices fall below the count so that unions build
  // deep trees; a few are drawn over the whole 8-bit range to hit the flag.
  task automatic random_request(int span);
    logic [IDX_W-1:0] a, b;
    if ($urandom_range(0, 9) == 0) begin
      a = IDX_W'($urandom);
      b = IDX_W'($urandom);
    end else begin
      a = IDX_W'($urandom_range(0, span - 1));
      b = IDX_W'($urandom_range(0, span - 1));
    end
    issue_request($urandom_range(0, 2) != 0 ? MODE_UNION : MODE_QUERY, a, b);
  endtask

  initial begin
    int span;
    tables = new();
    tables.clear();
    repeat (10) @(negedge clk);
    rst <= 0;

    // Directed part at the reset count: extremes, both modes, a union of two
    // roots already joined, equal-size ties and chained unions.
    issue_request(MODE_QUERY, 0, 255);
    issue_request(MODE_UNION, 0, 255);
    issue_request(MODE_QUERY, 255, 0);
    issue_request(MODE_UNION, 255, 0);
    issue_request(MODE_UNION, 1, 2);
    issue_request(MODE_UNION, 2, 0);
    issue_request(MODE_UNION, 170, 85);
    issue_request(MODE_QUERY, 1, 255);
    issue_request(MODE_QUERY, 7, 7);
    issue_request(MODE_UNION, 7, 7);

    // A count of zero flags everything; one leaves only element zero.
    set_element_count(0);
    issue_request(MODE_QUERY, 0, 0);
    issue_request(MODE_UNION, 0, 0);
    set_element_count(1);
    issue_request(MODE_QUERY, 0, 0);
    issue_request(MODE_UNION, 0, 1);
    // Above the table the count acts as the table size; links made earlier stay.
    set_element_count(9'h1FF);
    issue_request(MODE_QUERY, 2, 255);
    issue_request(MODE_UNION, 254, 3);
    set_element_count(100);
    issue_request(MODE_QUERY, 99, 100);
    issue_request(MODE_QUERY, 1, 99);

    // Random phases over several counts, small ones building deep trees quickly.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: span = 256;
        1: span = 2;
        2: span = 16;
        3: span = 256;
        4: span = $urandom_range(1, 256);
        5: span = 64;
        default: span = 256;
      endcase
      set_element_count(CNT_W'(span));
      if (phase == 6) quiet_phase = 1;
      repeat (200) random_request(span);
    end

    start <= 0;
    while (tables.pending_verdicts.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (tables.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
